### hw/rtl/ptpq_pkg.sv
// Shared widths and register codes for the pose to position and quaternion unit.
`timescale 1ns / 1ps

package ptpq_pkg;

    localparam int W_ROT = 18;
    localparam int W_POS = 20;
    localparam int W_OFF = 20;
    localparam int CFG_W = 20;
    localparam int CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OFFSET_X = 2'd0,
        CFG_OFFSET_Y = 2'd1,
        CFG_OFFSET_Z = 2'd2
    } cfg_index_t;

endpackage

### hw/rtl/ptpq_if.sv
// Request and result channel interfaces for the pose to position and quaternion unit.
`timescale 1ns / 1ps

interface ptpq_pose_if;
    import ptpq_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [W_ROT-1:0] rot_00;
    logic signed [W_ROT-1:0] rot_01;
    logic signed [W_ROT-1:0] rot_02;
    logic signed [W_ROT-1:0] rot_10;
    logic signed [W_ROT-1:0] rot_11;
    logic signed [W_ROT-1:0] rot_12;
    logic signed [W_ROT-1:0] rot_20;
    logic signed [W_ROT-1:0] rot_21;
    logic signed [W_ROT-1:0] rot_22;
    logic signed [W_POS-1:0] pos_in_x;
    logic signed [W_POS-1:0] pos_in_y;
    logic signed [W_POS-1:0] pos_in_z;

    modport source (
        output valid, rot_00, rot_01, rot_02, rot_10, rot_11, rot_12,
               rot_20, rot_21, rot_22, pos_in_x, pos_in_y, pos_in_z,
        input  ready
    );
    modport sink (
        input  valid, rot_00, rot_01, rot_02, rot_10, rot_11, rot_12,
               rot_20, rot_21, rot_22, pos_in_x, pos_in_y, pos_in_z,
        output ready
    );
endinterface

interface ptpq_result_if;
    import ptpq_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [W_POS-1:0] pos_x;
    logic signed [W_POS-1:0] pos_y;
    logic signed [W_POS-1:0] pos_z;
    logic signed [W_ROT-1:0] quat_x;
    logic signed [W_ROT-1:0] quat_y;
    logic signed [W_ROT-1:0] quat_z;
    logic signed [W_ROT-1:0] quat_w;

    modport source (
        output valid, pos_x, pos_y, pos_z, quat_x, quat_y, quat_z, quat_w,
        input  ready
    );
    modport sink (
        input  valid, pos_x, pos_y, pos_z, quat_x, quat_y, quat_z, quat_w,
        output ready
    );
endinterface

### hw/rtl/ptpq_delay.sv
// Enabled shift line that carries side data alongside the arithmetic stages.
`timescale 1ns / 1ps

module ptpq_delay #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic [WIDTH-1:0] d,
    output logic [WIDTH-1:0] q
);

    logic [WIDTH-1:0] stage_reg [DEPTH];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                stage_reg[i] <= '0;
            end
        end
        else if (en)
        begin
            stage_reg[0] <= d;
            for (int i = 1; i < DEPTH; i++)
            begin
                stage_reg[i] <= stage_reg[i-1];
            end
        end
    end

    assign q = stage_reg[DEPTH-1];

endmodule

### hw/rtl/ptpq_isqrt.sv
// Pipelined integer square root, one result bit per register stage.
`timescale 1ns / 1ps

module ptpq_isqrt #(
    parameter int IN_W = 4
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic [IN_W-1:0]          radicand,
    output logic [(IN_W+1)/2-1:0]    root
);

    localparam int K  = (IN_W + 1) / 2;
    localparam int RW = K + 2;
    localparam int XW = 2 * K;

    logic [RW-1:0] rem_reg  [K];
    logic [K-1:0]  root_reg [K];
    logic [XW-1:0] x_reg    [K];

    for (genvar i = 0; i < K; i++)
    begin : g_step
        logic [RW-1:0] rem_prev;
        logic [RW-1:0] rem_sh;
        logic [RW-1:0] trial;
        logic [RW-1:0] rem_next;
        logic [K-1:0]  root_prev;
        logic [K-1:0]  root_next;
        logic [XW-1:0] x_prev;
        logic [XW-1:0] x_next;

        if (i == 0)
        begin : g_first
            assign rem_prev  = '0;
            assign root_prev = '0;
            assign x_prev    = XW'(radicand);
        end
        else
        begin : g_rest
            assign rem_prev  = rem_reg[i-1];
            assign root_prev = root_reg[i-1];
            assign x_prev    = x_reg[i-1];
        end

        // The remainder never exceeds twice the partial root, so K bits carry it.
        always_comb
        begin
            rem_sh = {rem_prev[K-1:0], x_prev[XW-1 -: 2]};
            trial  = {root_prev, 2'b01};
            if (rem_sh >= trial)
            begin
                rem_next  = rem_sh - trial;
                root_next = {root_prev[K-2:0], 1'b1};
            end
            else
            begin
                rem_next  = rem_sh;
                root_next = {root_prev[K-2:0], 1'b0};
            end
            x_next = {x_prev[XW-3:0], 2'b00};
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i]  <= rem_next;
                root_reg[i] <= root_next;
                x_reg[i]    <= x_next;
            end
        end
    end

    assign root = root_reg[K-1];

endmodule

### hw/rtl/ptpq_div.sv
// Pipelined restoring divider, one quotient bit per register stage.
`timescale 1ns / 1ps

module ptpq_div #(
    parameter int DVD_W = 8,
    parameter int DVS_W = 4,
    parameter int Q_W   = 4
) (
    input  logic             clk,
    input  logic             en,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic [Q_W-1:0]   quotient
);

    // The upper dividend bits must already be below the divisor.
    logic [DVS_W-1:0] rem_reg [Q_W];
    logic [Q_W-1:0]   lq_reg  [Q_W];
    logic [DVS_W-1:0] dvs_reg [Q_W];

    for (genvar i = 0; i < Q_W; i++)
    begin : g_step
        logic [DVS_W-1:0] rem_prev;
        logic [Q_W-1:0]   lq_prev;
        logic [DVS_W-1:0] dvs_prev;
        logic [DVS_W:0]   rem_sh;
        logic [DVS_W:0]   diff;
        logic             ge;
        logic [DVS_W-1:0] rem_next;
        logic [Q_W-1:0]   lq_next;

        if (i == 0)
        begin : g_first
            assign rem_prev = DVS_W'(dividend[DVD_W-1:Q_W]);
            assign lq_prev  = dividend[Q_W-1:0];
            assign dvs_prev = divisor;
        end
        else
        begin : g_rest
            assign rem_prev = rem_reg[i-1];
            assign lq_prev  = lq_reg[i-1];
            assign dvs_prev = dvs_reg[i-1];
        end

        // Low dividend bits shift out at the top while quotient bits enter below.
        always_comb
        begin
            rem_sh   = {rem_prev, lq_prev[Q_W-1]};
            diff     = rem_sh - {1'b0, dvs_prev};
            ge       = (rem_sh >= {1'b0, dvs_prev});
            rem_next = ge ? diff[DVS_W-1:0] : rem_sh[DVS_W-1:0];
            lq_next  = {lq_prev[Q_W-2:0], ge};
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i] <= rem_next;
                lq_reg[i]  <= lq_next;
                dvs_reg[i] <= dvs_prev;
            end
        end
    end

    assign quotient = lq_reg[Q_W-1];

endmodule

### hw/rtl/pose_to_position_quaternion_unit.sv
// Top level: offset point and unit quaternion from a rotation matrix and position.
`timescale 1ns / 1ps

// MW is the candidate square root width and NW = MW + 1 the norm square root width.
// Throughput: one request per cycle unless a result waits, set by the bit-per-stage square
// root and divider pipelines. The whole pipeline stalls only while a result waits.
// Reset clears the valid bits, the delay lines and the tool offset registers; the stage and
// output payload registers are not reset.

module pose_to_position_quaternion_unit #(
    parameter int FRAC_BITS = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    ptpq_pose_if.sink                          pose,
    ptpq_result_if.source                      result,
    input  logic                               cfg_we,
    input  logic [ptpq_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ptpq_pkg::CFG_W-1:0]         cfg_data
);
    import ptpq_pkg::*;

    localparam int F       = FRAC_BITS;
    // Signed width of the diagonal candidates before clamping.
    localparam int VW      = ((F > 17) ? F : 17) + 3;
    localparam int UW      = VW - 1;
    localparam int RAD_W   = UW + F;
    localparam int MW      = (RAD_W + 1) / 2;
    localparam int SQ_W    = 2 * MW;
    localparam int SUM_W   = SQ_W + 2;
    localparam int NW      = (SUM_W + 1) / 2;
    localparam int QW      = F + 1;
    localparam int DVD_W   = MW + F + 1;
    localparam int PROD_W  = W_OFF + W_ROT;
    localparam int PSW     = PROD_W + 3;
    localparam int SIDE_W  = 3 * W_POS + 4;
    localparam int LAT     = 4 + MW + NW + QW;
    localparam int QMAX    = 2 ** (W_ROT - 1) - 1;

    localparam logic signed [VW-1:0]  ONE_V   = VW'(1) <<< F;
    localparam logic [QW-1:0]         ONE_Q   = QW'(1) << F;
    localparam logic signed [PSW-1:0] HALF_P  = PSW'(1) <<< (F - 1);
    localparam logic signed [PSW-1:0] POS_MAX = PSW'(2 ** (W_POS - 1) - 1);
    localparam logic signed [PSW-1:0] POS_MIN = -PSW'(2 ** (W_POS - 1));

    // The whole pipeline advances whenever the output register is empty or being taken.
    logic en;
    logic out_valid_reg;

    assign en          = !out_valid_reg || result.ready;
    assign pose.ready  = en;

    // Tool offset registers.
    logic signed [W_OFF-1:0] off_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            off_reg[0] <= '0;
            off_reg[1] <= '0;
            off_reg[2] <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_OFFSET_X: off_reg[0] <= cfg_data[W_OFF-1:0];
                CFG_OFFSET_Y: off_reg[1] <= cfg_data[W_OFF-1:0];
                CFG_OFFSET_Z: off_reg[2] <= cfg_data[W_OFF-1:0];
                default: ;
            endcase
        end
    end

    // Stage A: the nine offset products, the clamped diagonal candidates, the sign bits of
    // the off-diagonal sums and differences, and the input position.
    logic signed [PROD_W-1:0] prod_a_reg [9];
    logic [UW-1:0]            vcl_a_reg  [4];
    logic [5:0]               sgn_a_reg;
    logic signed [W_POS-1:0]  base_a_reg [3];

    logic signed [VW-1:0]     v_cand [4];
    logic signed [W_ROT:0]    od     [6];
    logic signed [W_ROT-1:0]  rot    [9];

    assign rot[0] = pose.rot_00;
    assign rot[1] = pose.rot_01;
    assign rot[2] = pose.rot_02;
    assign rot[3] = pose.rot_10;
    assign rot[4] = pose.rot_11;
    assign rot[5] = pose.rot_12;
    assign rot[6] = pose.rot_20;
    assign rot[7] = pose.rot_21;
    assign rot[8] = pose.rot_22;

    always_comb
    begin
        v_cand[0] = ONE_V + VW'(rot[0]) + VW'(rot[4]) + VW'(rot[8]);
        v_cand[1] = ONE_V + VW'(rot[0]) - VW'(rot[4]) - VW'(rot[8]);
        v_cand[2] = ONE_V - VW'(rot[0]) + VW'(rot[4]) - VW'(rot[8]);
        v_cand[3] = ONE_V - VW'(rot[0]) - VW'(rot[4]) + VW'(rot[8]);
        // Differences r21-r12, r02-r20, r10-r01, then sums r10+r01, r02+r20, r21+r12.
        od[0] = (W_ROT+1)'(rot[7]) - (W_ROT+1)'(rot[5]);
        od[1] = (W_ROT+1)'(rot[2]) - (W_ROT+1)'(rot[6]);
        od[2] = (W_ROT+1)'(rot[3]) - (W_ROT+1)'(rot[1]);
        od[3] = (W_ROT+1)'(rot[3]) + (W_ROT+1)'(rot[1]);
        od[4] = (W_ROT+1)'(rot[2]) + (W_ROT+1)'(rot[6]);
        od[5] = (W_ROT+1)'(rot[7]) + (W_ROT+1)'(rot[5]);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int r = 0; r < 3; r++)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    prod_a_reg[3*r+c] <= off_reg[c] * rot[3*r+c];
                end
            end
            for (int i = 0; i < 4; i++)
            begin
                vcl_a_reg[i] <= v_cand[i][VW-1] ? '0 : v_cand[i][UW-1:0];
            end
            for (int i = 0; i < 6; i++)
            begin
                sgn_a_reg[i] <= od[i][W_ROT];
            end
            base_a_reg[0] <= pose.pos_in_x;
            base_a_reg[1] <= pose.pos_in_y;
            base_a_reg[2] <= pose.pos_in_z;
        end
    end

    // Stage B: rounded offset point with saturation, the scaled candidates and the signs of the winner.
    logic signed [W_POS-1:0] pos_b_reg [3];
    logic [3:0]              neg_b_reg;
    logic [RAD_W-1:0]        rad_b_reg [4];

    logic [1:0]              win;
    logic [UW-1:0]           best;
    logic [3:0]              neg_sel;
    logic signed [PSW-1:0]   psum   [3];
    logic signed [PSW-1:0]   ptotal [3];
    logic signed [W_POS-1:0] psat   [3];

    always_comb
    begin
        win  = 2'd0;
        best = vcl_a_reg[0];
        for (int i = 1; i < 4; i++)
        begin
            if (vcl_a_reg[i] > best)
            begin
                win  = 2'(i);
                best = vcl_a_reg[i];
            end
        end

        neg_sel = 4'b0000;
        case (win)
            2'd0: neg_sel = {sgn_a_reg[2], sgn_a_reg[1], sgn_a_reg[0], 1'b0};
            2'd1: neg_sel = {sgn_a_reg[4], sgn_a_reg[3], 1'b0, sgn_a_reg[0]};
            2'd2: neg_sel = {sgn_a_reg[5], 1'b0, sgn_a_reg[3], sgn_a_reg[1]};
            2'd3: neg_sel = {1'b0, sgn_a_reg[5], sgn_a_reg[4], sgn_a_reg[2]};
            default: neg_sel = 4'b0000;
        endcase

        for (int r = 0; r < 3; r++)
        begin
            psum[r]   = PSW'(prod_a_reg[3*r]) + PSW'(prod_a_reg[3*r+1])
                      + PSW'(prod_a_reg[3*r+2]) + HALF_P;
            ptotal[r] = (psum[r] >>> F) + PSW'(base_a_reg[r]);
            if (ptotal[r] > POS_MAX)
            begin
                psat[r] = POS_MAX[W_POS-1:0];
            end
            else if (ptotal[r] < POS_MIN)
            begin
                psat[r] = POS_MIN[W_POS-1:0];
            end
            else
            begin
                psat[r] = ptotal[r][W_POS-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int r = 0; r < 3; r++)
            begin
                pos_b_reg[r] <= psat[r];
            end
            neg_b_reg <= neg_sel;
            for (int i = 0; i < 4; i++)
            begin
                rad_b_reg[i] <= RAD_W'(vcl_a_reg[i]) << F;
            end
        end
    end

    // Candidate square roots, four lanes side by side.
    logic [MW-1:0]   m_root [4];
    logic [4*MW-1:0] m_pack;
    logic [4*MW-1:0] m_dly;

    for (genvar i = 0; i < 4; i++)
    begin : g_cand
        ptpq_isqrt #(
            .IN_W (RAD_W)
        ) u_isqrt (
            .clk      (clk),
            .en       (en),
            .radicand (rad_b_reg[i]),
            .root     (m_root[i])
        );
    end

    assign m_pack = {m_root[3], m_root[2], m_root[1], m_root[0]};

    // Stage C squares the roots, stage D sums them.
    logic [SQ_W-1:0]  sq_c_reg [4];
    logic [SUM_W-1:0] sum_d_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 4; i++)
            begin
                sq_c_reg[i] <= m_root[i] * m_root[i];
            end
            sum_d_reg <= SUM_W'(sq_c_reg[0]) + SUM_W'(sq_c_reg[1])
                       + SUM_W'(sq_c_reg[2]) + SUM_W'(sq_c_reg[3]);
        end
    end

    logic [NW-1:0] norm;

    ptpq_isqrt #(
        .IN_W (SUM_W)
    ) u_norm (
        .clk      (clk),
        .en       (en),
        .radicand (sum_d_reg),
        .root     (norm)
    );

    ptpq_delay #(
        .WIDTH (4 * MW),
        .DEPTH (2 + NW)
    ) u_m_dly (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (en),
        .d     (m_pack),
        .q     (m_dly)
    );

    // Each lane divides its root, scaled to one, by the norm with rounding to nearest.
    logic [QW-1:0] mag [4];

    for (genvar i = 0; i < 4; i++)
    begin : g_lane
        logic [DVD_W-1:0] dvd;

        assign dvd = (DVD_W'(m_dly[i*MW +: MW]) << F) + DVD_W'(norm >> 1);

        ptpq_div #(
            .DVD_W (DVD_W),
            .DVS_W (NW),
            .Q_W   (QW)
        ) u_div (
            .clk      (clk),
            .en       (en),
            .dividend (dvd),
            .divisor  (norm),
            .quotient (mag[i])
        );
    end

    // Side data: position and signs follow the whole arithmetic path, the zero-norm flag
    // follows the divider only.
    logic [SIDE_W-1:0] side_d;
    logic [SIDE_W-1:0] side_q;
    logic              nzero_q;
    logic              valid_q;

    assign side_d = {pos_b_reg[0], pos_b_reg[1], pos_b_reg[2], neg_b_reg};

    ptpq_delay #(
        .WIDTH (SIDE_W),
        .DEPTH (MW + 2 + NW + QW)
    ) u_side_dly (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (en),
        .d     (side_d),
        .q     (side_q)
    );

    ptpq_delay #(
        .WIDTH (1),
        .DEPTH (QW)
    ) u_nzero_dly (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (en),
        .d     (norm == '0),
        .q     (nzero_q)
    );

    ptpq_delay #(
        .WIDTH (1),
        .DEPTH (LAT)
    ) u_valid_dly (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (en),
        .d     (pose.valid),
        .q     (valid_q)
    );

    // Applies the sign and saturates a quaternion magnitude to the output width.
    function automatic logic signed [W_ROT-1:0] sat_quat(input logic [QW-1:0] m,
                                                        input logic neg);
        logic [31:0] m32;
        m32 = 32'(m);
        if (!neg)
        begin
            sat_quat = (m32 > 32'(QMAX)) ? W_ROT'(QMAX) : m32[W_ROT-1:0];
        end
        else
        begin
            sat_quat = (m32 > 32'(QMAX + 1)) ? -W_ROT'(QMAX + 1) : -m32[W_ROT-1:0];
        end
    endfunction

    // Stage E: output register. Lane 0 is the scalar part, lanes 1 to 3 are x, y and z.
    logic signed [W_POS-1:0] pos_out_reg [3];
    logic signed [W_ROT-1:0] quat_reg    [4];
    logic [QW-1:0]           mag_sel     [4];
    logic [3:0]              neg_fin;

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            if (nzero_q)
            begin
                mag_sel[i] = (i == 0) ? ONE_Q : '0;
                neg_fin[i] = 1'b0;
            end
            else
            begin
                mag_sel[i] = mag[i];
                neg_fin[i] = side_q[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= valid_q;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pos_out_reg[0] <= side_q[SIDE_W-1 -: W_POS];
            pos_out_reg[1] <= side_q[SIDE_W-1-W_POS -: W_POS];
            pos_out_reg[2] <= side_q[SIDE_W-1-2*W_POS -: W_POS];
            for (int i = 0; i < 4; i++)
            begin
                quat_reg[i] <= sat_quat(mag_sel[i], neg_fin[i]);
            end
        end
    end

    assign result.valid  = out_valid_reg;
    assign result.pos_x  = pos_out_reg[0];
    assign result.pos_y  = pos_out_reg[1];
    assign result.pos_z  = pos_out_reg[2];
    assign result.quat_w = quat_reg[0];
    assign result.quat_x = quat_reg[1];
    assign result.quat_y = quat_reg[2];
    assign result.quat_z = quat_reg[3];

endmodule
